/* hdl/long_press_event_queue_unit_defines.svh */
// Assertion macros used by the checker file of the event queue.
// Depends on nothing; included by name where assertions are written.
`ifndef LONG_PRESS_EVENT_QUEUE_UNIT_DEFINES_SVH
`define LONG_PRESS_EVENT_QUEUE_UNIT_DEFINES_SVH

// Clocked check that is switched off while reset is high.
`define LPEQ_ASSERT_ACTIVE(lbl, clk_sig, rst_sig, prop) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) \
    else $error("lpeq check failed");

// Clocked check that also holds through reset.
`define LPEQ_ASSERT_ALWAYS(lbl, clk_sig, prop) \
  lbl: assert property (@(posedge clk_sig) prop) \
    else $error("lpeq reset check failed");

`endif

/* hdl/lpeq_pkg.sv */
// Types, codes and sizing constants of the long-press event queue.
// No dependencies; used by every module of the block by scoped names.
package lpeq_pkg;

  localparam int RING_DEPTH = 64;
  // Physical storage is split into an even and an odd bank so that two
  // consecutive pushes always land in different banks.
  localparam int BANK_DEPTH = (RING_DEPTH + 1) / 2;
  localparam int PHYS_DEPTH = 2 * BANK_DEPTH;
  localparam int PTR_W      = $clog2(PHYS_DEPTH);
  localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int CNT_W      = $clog2(RING_DEPTH);

  localparam int TIME_W     = 16;
  localparam int S_TDATA_W  = 24;
  localparam int M_TDATA_W  = 8;

  localparam logic       CMD_TICK = 1'b0;
  localparam logic       CMD_POP  = 1'b1;

  localparam logic [1:0] ROT_NONE  = 2'd0;
  localparam logic [1:0] ROT_RIGHT = 2'd1;
  localparam logic [1:0] ROT_LEFT  = 2'd2;

  localparam logic [1:0] LED_OFF = 2'd0;
  localparam logic [1:0] LED_1   = 2'd1;
  localparam logic [1:0] LED_2   = 2'd2;
  localparam logic [1:0] LED_3   = 2'd3;

  localparam logic [1:0] CFG_BACKSPACE_MIN = 2'd0;
  localparam logic [1:0] CFG_DELETE_ABOVE  = 2'd1;
  localparam logic [1:0] CFG_ESCAPE_ABOVE  = 2'd2;

  localparam logic [TIME_W-1:0] BACKSPACE_MIN_RST = 16'd500;
  localparam logic [TIME_W-1:0] DELETE_ABOVE_RST  = 16'd1000;
  localparam logic [TIME_W-1:0] ESCAPE_ABOVE_RST  = 16'd1500;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_ENTER     = 3'd1,
    EV_BACKSPACE = 3'd2,
    EV_DELETE    = 3'd3,
    EV_ESCAPE    = 3'd4,
    EV_RIGHT     = 3'd5,
    EV_LEFT      = 3'd6
  } event_t;

  typedef struct packed {
    logic [1:0] led;
    event_t     armed;
    logic [1:0] push_cnt;
    event_t     push0;
    event_t     push1;
  } tick_result_t;

  typedef struct packed {
    logic       step;
    logic       pop;
    logic [1:0] push_cnt;
    event_t     push0;
    event_t     push1;
  } ring_req_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(PHYS_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [BANK_AW-1:0] bank_addr(input logic [PTR_W-1:0] p);
    return BANK_AW'(p >> 1);
  endfunction

endpackage

/* hdl/lpeq_classifier.sv */
// Press-time classification and push selection for one tick.
// Depends on lpeq_pkg.
module lpeq_classifier (
  input  logic [lpeq_pkg::TIME_W-1:0] press_time,
  input  logic [1:0]                  rotation,
  input  logic [lpeq_pkg::TIME_W-1:0] last_press_time,
  input  lpeq_pkg::event_t            armed_event,
  input  logic [lpeq_pkg::TIME_W-1:0] backspace_min,
  input  logic [lpeq_pkg::TIME_W-1:0] delete_above,
  input  logic [lpeq_pkg::TIME_W-1:0] escape_above,
  output lpeq_pkg::tick_result_t      result
);

  logic             release_ev;
  logic             rot_ev;
  lpeq_pkg::event_t rot_code;

  assign release_ev = (press_time == '0) && (last_press_time != '0);

  always_comb begin
    rot_ev   = 1'b0;
    rot_code = lpeq_pkg::EV_RIGHT;
    unique case (rotation)
      lpeq_pkg::ROT_RIGHT: begin
        rot_ev   = 1'b1;
        rot_code = lpeq_pkg::EV_RIGHT;
      end
      lpeq_pkg::ROT_LEFT: begin
        rot_ev   = 1'b1;
        rot_code = lpeq_pkg::EV_LEFT;
      end
      default: begin
        rot_ev   = 1'b0;
        rot_code = lpeq_pkg::EV_RIGHT;
      end
    endcase
  end

  always_comb begin
    result.led   = lpeq_pkg::LED_OFF;
    result.armed = lpeq_pkg::EV_ENTER;
    priority if (release_ev) begin
      result.led   = lpeq_pkg::LED_OFF;
      result.armed = lpeq_pkg::EV_ENTER;
    end else if (press_time < backspace_min) begin
      result.led   = lpeq_pkg::LED_OFF;
      result.armed = lpeq_pkg::EV_ENTER;
    end else if (press_time <= delete_above) begin
      result.led   = lpeq_pkg::LED_1;
      result.armed = lpeq_pkg::EV_BACKSPACE;
    end else if (press_time <= escape_above) begin
      result.led   = lpeq_pkg::LED_2;
      result.armed = lpeq_pkg::EV_DELETE;
    end else begin
      result.led   = lpeq_pkg::LED_3;
      result.armed = lpeq_pkg::EV_ESCAPE;
    end
    // release event goes first, rotation after it
    result.push_cnt = {1'b0, release_ev} + {1'b0, rot_ev};
    result.push0    = release_ev ? armed_event : rot_code;
    result.push1    = rot_code;
  end

endmodule

/* hdl/lpeq_event_ring.sv */
// Overwriting event ring: two banks, pointers, fill count, registered read.
// Depends on lpeq_pkg.
module lpeq_event_ring (
  input  logic                clk,
  input  logic                rst,
  input  lpeq_pkg::ring_req_t req,
  output lpeq_pkg::event_t    event_code
);

  lpeq_pkg::event_t bank_even [lpeq_pkg::BANK_DEPTH];
  lpeq_pkg::event_t bank_odd  [lpeq_pkg::BANK_DEPTH];

  logic [lpeq_pkg::PTR_W-1:0] rd_ptr, rd_ptr_next;
  logic [lpeq_pkg::PTR_W-1:0] wr_ptr, wr_ptr_next;
  logic [lpeq_pkg::PTR_W-1:0] wr_ptr1;
  logic [lpeq_pkg::CNT_W-1:0] count, count_next;
  logic                       pop_hit;

  logic                         we_even, we_odd;
  logic [lpeq_pkg::BANK_AW-1:0] wa_even, wa_odd;
  lpeq_pkg::event_t             wd_even, wd_odd;

  lpeq_pkg::event_t rdata_even, rdata_odd;
  logic             rd_sel;
  logic             rd_hit;

  localparam logic [lpeq_pkg::CNT_W-1:0] CNT_MAX = lpeq_pkg::CNT_W'(lpeq_pkg::RING_DEPTH - 1);

  assign wr_ptr1 = lpeq_pkg::ptr_inc(wr_ptr);
  assign pop_hit = req.pop && (count != '0);

  // A push into a full ring drops the oldest entry by moving the read side.
  always_comb begin
    rd_ptr_next = rd_ptr;
    wr_ptr_next = wr_ptr;
    count_next  = count;
    if (req.step) begin
      if (req.pop) begin
        if (pop_hit) begin
          rd_ptr_next = lpeq_pkg::ptr_inc(rd_ptr);
          count_next  = count - 1'b1;
        end
      end else begin
        if (req.push_cnt != 2'd0) begin
          wr_ptr_next = wr_ptr1;
          if (count == CNT_MAX) begin
            rd_ptr_next = lpeq_pkg::ptr_inc(rd_ptr);
          end else begin
            count_next = count + 1'b1;
          end
        end
        if (req.push_cnt == 2'd2) begin
          wr_ptr_next = lpeq_pkg::ptr_inc(wr_ptr1);
          if (count_next == CNT_MAX) begin
            rd_ptr_next = lpeq_pkg::ptr_inc(rd_ptr_next);
          end else begin
            count_next = count_next + 1'b1;
          end
        end
      end
    end
  end

  // first push goes to the bank of wr_ptr, the second to the other bank
  always_comb begin
    we_even = req.step && !req.pop &&
              (((req.push_cnt != 2'd0) && !wr_ptr[0]) || ((req.push_cnt == 2'd2) && wr_ptr[0]));
    we_odd  = req.step && !req.pop &&
              (((req.push_cnt != 2'd0) && wr_ptr[0]) || ((req.push_cnt == 2'd2) && !wr_ptr[0]));
    wd_even = wr_ptr[0] ? req.push1 : req.push0;
    wd_odd  = wr_ptr[0] ? req.push0 : req.push1;
    wa_even = wr_ptr[0] ? lpeq_pkg::bank_addr(wr_ptr1) : lpeq_pkg::bank_addr(wr_ptr);
    wa_odd  = wr_ptr[0] ? lpeq_pkg::bank_addr(wr_ptr) : lpeq_pkg::bank_addr(wr_ptr1);
  end

  always_ff @(posedge clk) begin
    if (we_even) begin
      bank_even[wa_even] <= wd_even;
    end
    if (we_odd) begin
      bank_odd[wa_odd] <= wd_odd;
    end
  end

  always_ff @(posedge clk) begin
    if (req.step && req.pop) begin
      rdata_even <= bank_even[lpeq_pkg::bank_addr(rd_ptr)];
      rdata_odd  <= bank_odd[lpeq_pkg::bank_addr(rd_ptr)];
      rd_sel     <= rd_ptr[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
      rd_hit <= 1'b0;
    end else begin
      rd_ptr <= rd_ptr_next;
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (req.step) begin
        rd_hit <= pop_hit;
      end
    end
  end

  assign event_code = !rd_hit ? lpeq_pkg::EV_NONE : (rd_sel ? rdata_odd : rdata_even);

endmodule

/* hdl/long_press_event_queue_unit.sv */
// Long-press event queue: input stage, tick state, threshold registers, ring.
// Depends on lpeq_pkg, lpeq_classifier and lpeq_event_ring.
//
// Usage:
//   s_* carries one beat per tick or pop: s_tuser is the command (0 tick,
//   1 pop), s_tdata the press time and the rotary step. Every accepted beat
//   yields exactly one beat on m_*: the LED select after a tick, or the
//   popped event code (none when the ring is empty) after a pop.
//   cfg_* writes the three press-time thresholds; cfg_ready is always high.
//   The input register takes a beat; classification and the ring update then
//   load the output register and the ring's registered read port, and
//   m_tvalid rises once both are loaded. Throughput is one beat per cycle
//   while the receiver does not stall; a tick may push two events at once
//   since they go to separate banks.
//   When the receiver stalls, the output register holds its beat and the
//   input register takes one more beat before s_tready drops.
//   Reset clears the pipeline, ring pointers and fill count, the last press
//   time and the armed event (enter), and loads the default thresholds.
//   Ring storage is not cleared; only written entries are ever popped.
module long_press_event_queue_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [lpeq_pkg::S_TDATA_W-1:0]   s_tdata,   // press_time[15:0], rotation[17:16], zero pad
  input  logic                             s_tuser,   // command
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [lpeq_pkg::M_TDATA_W-1:0]   m_tdata,   // led_select[1:0], event_code[4:2], zero pad
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [1:0]                       cfg_index,
  input  logic [lpeq_pkg::TIME_W-1:0]      cfg_data
);

  logic                        s1_valid;
  logic                        s1_command;
  logic [lpeq_pkg::TIME_W-1:0] s1_press_time;
  logic [1:0]                  s1_rotation;

  logic       s2_valid;
  logic [1:0] s2_led;

  logic                        s2_free;
  logic                        step;

  logic [lpeq_pkg::TIME_W-1:0] last_press_time;
  lpeq_pkg::event_t            armed_event;
  logic [lpeq_pkg::TIME_W-1:0] backspace_min;
  logic [lpeq_pkg::TIME_W-1:0] delete_above;
  logic [lpeq_pkg::TIME_W-1:0] escape_above;

  lpeq_pkg::tick_result_t tick;
  lpeq_pkg::ring_req_t    ring_req;
  lpeq_pkg::event_t       event_code;

  assign s2_free  = !s2_valid || m_tready;
  assign step     = s1_valid && s2_free;
  assign s_tready = !s1_valid || s2_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_command    <= s_tuser;
      s1_press_time <= s_tdata[15:0];
      s1_rotation   <= s_tdata[17:16];
    end
  end

  lpeq_classifier u_classifier (
    .press_time      (s1_press_time),
    .rotation        (s1_rotation),
    .last_press_time (last_press_time),
    .armed_event     (armed_event),
    .backspace_min   (backspace_min),
    .delete_above    (delete_above),
    .escape_above    (escape_above),
    .result          (tick)
  );

  always_comb begin
    ring_req.step     = step;
    ring_req.pop      = (s1_command == lpeq_pkg::CMD_POP);
    ring_req.push_cnt = tick.push_cnt;
    ring_req.push0    = tick.push0;
    ring_req.push1    = tick.push1;
  end

  lpeq_event_ring u_ring (
    .clk        (clk),
    .rst        (rst),
    .req        (ring_req),
    .event_code (event_code)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      last_press_time <= '0;
      armed_event     <= lpeq_pkg::EV_ENTER;
    end else if (step && (s1_command == lpeq_pkg::CMD_TICK)) begin
      last_press_time <= s1_press_time;
      armed_event     <= tick.armed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      s2_led <= (s1_command == lpeq_pkg::CMD_POP) ? lpeq_pkg::LED_OFF : tick.led;
    end
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      backspace_min <= lpeq_pkg::BACKSPACE_MIN_RST;
      delete_above  <= lpeq_pkg::DELETE_ABOVE_RST;
      escape_above  <= lpeq_pkg::ESCAPE_ABOVE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lpeq_pkg::CFG_BACKSPACE_MIN: backspace_min <= cfg_data;
        lpeq_pkg::CFG_DELETE_ABOVE:  delete_above  <= cfg_data;
        lpeq_pkg::CFG_ESCAPE_ABOVE:  escape_above  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign m_tvalid = s2_valid;
  assign m_tdata  = {3'b000, event_code, s2_led};

endmodule

/* hdl/lpeq_checker.sv */
// Port-level checks of the long-press event queue, bound to the top level.
// Depends on long_press_event_queue_unit_defines.svh and lpeq_pkg.
`include "long_press_event_queue_unit_defines.svh"

module lpeq_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [lpeq_pkg::M_TDATA_W-1:0] m_tdata
);

  // no beat can be pending right after reset
  `LPEQ_ASSERT_ALWAYS(a_reset_clears_out, clk, rst |=> !m_tvalid)

  // a beat is either a tick (no event) or a pop (LED off)
  `LPEQ_ASSERT_ACTIVE(a_tick_or_pop, clk, rst, m_tvalid |-> ((m_tdata[1:0] == 2'd0) || (m_tdata[4:2] == 3'd0)))

  // no unused event code and clean padding
  `LPEQ_ASSERT_ACTIVE(a_code_range, clk, rst, m_tvalid |-> ((m_tdata[4:2] != 3'd7) && (m_tdata[7:5] == 3'd0)))

  // an empty output stage always lets the input side move
  `LPEQ_ASSERT_ACTIVE(a_ready_when_drained, clk, rst, !m_tvalid |-> s_tready)

  // stalled beat is held
  `LPEQ_ASSERT_ACTIVE(a_out_hold, clk, rst, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))

endmodule

bind long_press_event_queue_unit lpeq_checker u_lpeq_checker (.*);

/* dv/testbench.sv */
// Self-checking testbench for long_press_event_queue_unit: directed and random ticks/pops,
// threshold writes between phases, random stalls on both streams, in-order result checks.
// Depends on lpeq_pkg and the RTL of the block.
`timescale 1ns / 100ps

module testbench;

  localparam logic [1:0] ROT_UNUSED    = 2'd3;
  localparam int         ROT_LSB       = lpeq_pkg::TIME_W;
  localparam int         STALL_HOLD    = 300;
  localparam int         IDLE_LIMIT    = 5000;
  localparam int         SETTLE_CYCLES = 10;
  localparam int         PHASE_ITEMS   = 280;
  localparam int         REPORT_MAX    = 10;

  typedef struct {
    logic [1:0]       led;
    lpeq_pkg::event_t code;
  } queue_result_t;

  // Mirrors thresholds, ring and press history; holds results still owed by the block.
  class event_queue_scoreboard;
    logic [lpeq_pkg::TIME_W-1:0] backspace_min;
    logic [lpeq_pkg::TIME_W-1:0] delete_above;
    logic [lpeq_pkg::TIME_W-1:0] escape_above;
    logic [lpeq_pkg::TIME_W-1:0] last_press;
    lpeq_pkg::event_t            armed;
    lpeq_pkg::event_t            ring [lpeq_pkg::RING_DEPTH];
    int                          rd_ptr;
    int                          wr_ptr;
    queue_result_t               owed_q[$];
    int                          mismatches;

    function new();
      backspace_min = lpeq_pkg::BACKSPACE_MIN_RST;
      delete_above  = lpeq_pkg::DELETE_ABOVE_RST;
      escape_above  = lpeq_pkg::ESCAPE_ABOVE_RST;
      last_press    = '0;
      armed         = lpeq_pkg::EV_ENTER;
      rd_ptr        = 0;
      wr_ptr        = 0;
      mismatches    = 0;
      foreach (ring[i]) ring[i] = lpeq_pkg::EV_NONE;
    endfunction

    function void set_threshold(logic [1:0] idx, logic [lpeq_pkg::TIME_W-1:0] value);
      case (idx)
        lpeq_pkg::CFG_BACKSPACE_MIN: backspace_min = value;
        lpeq_pkg::CFG_DELETE_ABOVE:  delete_above  = value;
        lpeq_pkg::CFG_ESCAPE_ABOVE:  escape_above  = value;
        default: ;
      endcase
    endfunction

    // full ring drops the oldest entry
    function void push_event(lpeq_pkg::event_t ev);
      ring[wr_ptr] = ev;
      wr_ptr = (wr_ptr + 1) % lpeq_pkg::RING_DEPTH;
      if (rd_ptr == wr_ptr) rd_ptr = (rd_ptr + 1) % lpeq_pkg::RING_DEPTH;
    endfunction

    function void note_input(logic cmd, logic [lpeq_pkg::TIME_W-1:0] press, logic [1:0] rot);
      queue_result_t r;
      r.led  = lpeq_pkg::LED_OFF;
      r.code = lpeq_pkg::EV_NONE;
      if (cmd == lpeq_pkg::CMD_POP) begin
        if (rd_ptr != wr_ptr) begin
          r.code = ring[rd_ptr];
          rd_ptr = (rd_ptr + 1) % lpeq_pkg::RING_DEPTH;
        end
      end else begin
        if (press == '0 && last_press != '0) begin
          push_event(armed);
          armed = lpeq_pkg::EV_ENTER;
        end else if (press < backspace_min) begin
          armed = lpeq_pkg::EV_ENTER;
        end else if (press <= delete_above) begin
          r.led = lpeq_pkg::LED_1;
          armed = lpeq_pkg::EV_BACKSPACE;
        end else if (press <= escape_above) begin
          r.led = lpeq_pkg::LED_2;
          armed = lpeq_pkg::EV_DELETE;
        end else begin
          r.led = lpeq_pkg::LED_3;
          armed = lpeq_pkg::EV_ESCAPE;
        end
        // rotary event goes in after any release event
        if (rot == lpeq_pkg::ROT_RIGHT) push_event(lpeq_pkg::EV_RIGHT);
        else if (rot == lpeq_pkg::ROT_LEFT) push_event(lpeq_pkg::EV_LEFT);
        last_press = press;
      end
      owed_q.push_back(r);
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= REPORT_MAX) $display("%0t: mismatch: %s", $time, msg);
    endfunction

    function void check_result(logic [lpeq_pkg::M_TDATA_W-1:0] beat);
      queue_result_t want;
      if (owed_q.size() == 0) begin
        flag($sformatf("output beat %0h with nothing pending", beat));
        return;
      end
      want = owed_q.pop_front();
      if (beat[1:0] !== want.led || beat[4:2] !== want.code ||
          beat[lpeq_pkg::M_TDATA_W-1:5] !== '0)
        flag($sformatf("got led %0d event %0d pad %0h, expected led %0d event %0d pad 0",
                       beat[1:0], beat[4:2], beat[lpeq_pkg::M_TDATA_W-1:5],
                       want.led, want.code));
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [lpeq_pkg::S_TDATA_W-1:0] s_tdata;
  logic                           s_tuser;
  logic                           m_tvalid;
  logic                           m_tready;
  logic [lpeq_pkg::M_TDATA_W-1:0] m_tdata;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [1:0]                     cfg_index;
  logic [lpeq_pkg::TIME_W-1:0]    cfg_data;

  event_queue_scoreboard sb = new();
  int items_sent;
  int idle_cycles;
  int no_gap_left;
  bit hold_request;

  always #5 clk = ~clk;

  long_press_event_queue_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // all handshakes are observed here, so predictor and checker never race
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.set_threshold(cfg_index, cfg_data);
      if (s_tvalid && s_tready)
        sb.note_input(s_tuser, s_tdata[lpeq_pkg::TIME_W-1:0], s_tdata[ROT_LSB+1:ROT_LSB]);
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("Testbench completed WITH ERRORS");
          $finish;
        end
      end
    end
  end

  // receiver: random ready pattern, plus one long hold-off on request
  initial begin
    int len;
    int r;
    m_tready = 1'b0;
    repeat (5) @(negedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        m_tready <= 1'b0;
        repeat (STALL_HOLD) @(negedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 15) begin
          m_tready <= 1'b0;
          len = $urandom_range(1, 4);
        end else if (r < 20) begin
          m_tready <= 1'b0;
          len = $urandom_range(10, 50);
        end else if (r < 25) begin
          m_tready <= 1'b1;
          len = $urandom_range(50, 150);
        end else begin
          m_tready <= 1'b1;
          len = $urandom_range(1, 12);
        end
        repeat (len) @(negedge clk);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_gap_left > 0) begin
      no_gap_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      no_gap_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // press times cluster on the thresholds and the field extremes
  function automatic logic [lpeq_pkg::TIME_W-1:0] pick_press();
    int base;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return lpeq_pkg::TIME_W'(int'(sb.backspace_min) - int'($urandom_range(0, 1)));
      3: return lpeq_pkg::TIME_W'(int'(sb.delete_above) + int'($urandom_range(0, 1)));
      4: return lpeq_pkg::TIME_W'(int'(sb.escape_above) + int'($urandom_range(0, 1)));
      5, 6: return lpeq_pkg::TIME_W'($urandom_range(1, 2000));
      7: return lpeq_pkg::TIME_W'($urandom);
      default: begin
        case ($urandom_range(0, 2))
          0: base = sb.backspace_min;
          1: base = sb.delete_above;
          default: base = sb.escape_above;
        endcase
        return lpeq_pkg::TIME_W'(base + int'($urandom_range(0, 6)) - 3);
      end
    endcase
  endfunction

  function automatic logic [1:0] pick_rot();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return lpeq_pkg::ROT_NONE;
    if (r < 7) return lpeq_pkg::ROT_RIGHT;
    if (r < 9) return lpeq_pkg::ROT_LEFT;
    return ROT_UNUSED;
  endfunction

  task automatic send_beat(logic cmd, logic [lpeq_pkg::TIME_W-1:0] press, logic [1:0] rot);
    int gap;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= lpeq_pkg::S_TDATA_W'({rot, press});
    do @(posedge clk); while (!s_tready);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // stop offering beats and wait for every owed result
  task automatic wait_all_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic write_threshold(logic [1:0] idx, logic [lpeq_pkg::TIME_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_thresholds(int bs, int del, int esc);
    write_threshold(lpeq_pkg::CFG_BACKSPACE_MIN, lpeq_pkg::TIME_W'(bs));
    write_threshold(lpeq_pkg::CFG_DELETE_ABOVE, lpeq_pkg::TIME_W'(del));
    write_threshold(lpeq_pkg::CFG_ESCAPE_ABOVE, lpeq_pkg::TIME_W'(esc));
  endtask

  // ramp up to a hold time, then release
  task automatic press_gesture();
    int steps;
    int target;
    steps  = $urandom_range(1, 6);
    target = pick_press();
    for (int i = 1; i <= steps; i++)
      send_beat(lpeq_pkg::CMD_TICK, lpeq_pkg::TIME_W'((target * i) / steps), pick_rot());
    send_beat(lpeq_pkg::CMD_TICK, '0, pick_rot());
  endtask

  task automatic run_random(int quota, int pop_pct);
    int stop_at;
    int r;
    int n;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < pop_pct) begin
        n = $urandom_range(1, 6);
        repeat (n) send_beat(lpeq_pkg::CMD_POP, lpeq_pkg::TIME_W'($urandom),
                             2'($urandom_range(0, 3)));
      end else if (r < pop_pct + 15) begin
        n = $urandom_range(1, 5);
        repeat (n) send_beat(lpeq_pkg::CMD_TICK, '0, 2'($urandom_range(1, 3)));
      end else if (r < pop_pct + 20) begin
        send_beat(1'($urandom_range(0, 1)), lpeq_pkg::TIME_W'($urandom),
                  2'($urandom_range(0, 3)));
      end else begin
        press_gesture();
      end
    end
  endtask

  task automatic directed_checks();
    send_beat(lpeq_pkg::CMD_POP, '0, lpeq_pkg::ROT_NONE);     // empty ring pops nothing
    send_beat(lpeq_pkg::CMD_TICK, '0, lpeq_pkg::ROT_NONE);    // zero after zero is no release
    send_beat(lpeq_pkg::CMD_TICK, lpeq_pkg::BACKSPACE_MIN_RST - 1'b1, lpeq_pkg::ROT_NONE);
    send_beat(lpeq_pkg::CMD_TICK, lpeq_pkg::BACKSPACE_MIN_RST, lpeq_pkg::ROT_NONE);
    send_beat(lpeq_pkg::CMD_TICK, lpeq_pkg::DELETE_ABOVE_RST, lpeq_pkg::ROT_NONE);
    send_beat(lpeq_pkg::CMD_TICK, lpeq_pkg::DELETE_ABOVE_RST + 1'b1, lpeq_pkg::ROT_NONE);
    send_beat(lpeq_pkg::CMD_TICK, lpeq_pkg::ESCAPE_ABOVE_RST, lpeq_pkg::ROT_NONE);
    send_beat(lpeq_pkg::CMD_TICK, lpeq_pkg::ESCAPE_ABOVE_RST + 1'b1, lpeq_pkg::ROT_NONE);
    send_beat(lpeq_pkg::CMD_TICK, '1, lpeq_pkg::ROT_RIGHT);
    send_beat(lpeq_pkg::CMD_TICK, '0, lpeq_pkg::ROT_LEFT);    // release and step: two pushes
    send_beat(lpeq_pkg::CMD_TICK, lpeq_pkg::BACKSPACE_MIN_RST, lpeq_pkg::ROT_NONE);
    send_beat(lpeq_pkg::CMD_TICK, '0, lpeq_pkg::ROT_NONE);
    send_beat(lpeq_pkg::CMD_TICK, 16'd1200, lpeq_pkg::ROT_NONE);
    send_beat(lpeq_pkg::CMD_TICK, '0, ROT_UNUSED);
    send_beat(lpeq_pkg::CMD_TICK, 16'd100, lpeq_pkg::ROT_NONE);
    send_beat(lpeq_pkg::CMD_TICK, '0, lpeq_pkg::ROT_NONE);
    repeat (7) send_beat(lpeq_pkg::CMD_POP, '0, lpeq_pkg::ROT_NONE);
  endtask

  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = lpeq_pkg::CMD_TICK;
    cfg_valid    = 1'b0;
    cfg_index    = lpeq_pkg::CFG_BACKSPACE_MIN;
    cfg_data     = '0;
    items_sent   = 0;
    idle_cycles  = 0;
    no_gap_left  = 0;
    hold_request = 1'b0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    directed_checks();
    run_random(PHASE_ITEMS, 20);
    wait_all_results();

    for (int phase = 1; phase <= 6; phase++) begin
      case (phase)
        1: set_thresholds(0, 0, 0);
        2: set_thresholds(65535, 65535, 65535);
        3: set_thresholds(2000, 300, 100);          // misordered
        4: begin
          int bs;
          int del;
          bs  = $urandom_range(0, 30000);
          del = bs + $urandom_range(0, 20000);
          set_thresholds(bs, del, del + $urandom_range(0, 15000));
        end
        5: set_thresholds($urandom_range(0, 65535), $urandom_range(0, 65535),
                          $urandom_range(0, 65535));
        default: set_thresholds(1, 65534, 65535);
      endcase
      run_random(PHASE_ITEMS / 2, (phase % 2) ? 10 : 40);
      if (phase == 2) hold_request = 1'b1;         // output backs up, input stalls
      if (phase == 3) wait_all_results();
      run_random(PHASE_ITEMS / 2, (phase % 2) ? 30 : 15);
      wait_all_results();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
